@@ hw/rtl/imrq_pkg.sv @@
// Shared constants, codes and types for the int8 MAC reduce and requantize block.
package imrq_pkg;

    localparam int ROW_SUM_BITS_DEF = 19;
    localparam int ACC_BITS_DEF     = 27;
    localparam int TILE_GROWTH      = 7;

    localparam int RAW_BITS   = 27;
    localparam int MULT_BITS  = 17;
    localparam int SHIFT_BITS = 6;

    localparam logic signed [31:0] MULT_MIN  = 32'sd65540;
    localparam logic signed [31:0] MULT_MAX  = 32'sd131067;
    localparam logic [7:0]         SHIFT_MIN = 8'd23;
    localparam logic [7:0]         SHIFT_MAX = 8'd32;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_REQUANT  = 2'd2;

    localparam logic CFG_RELU_ENABLE  = 1'b0;
    localparam logic CFG_TAPS_PER_ROW = 1'b1;

    typedef struct packed {
        logic [31:0] bias;
        logic [31:0] multiplier;
        logic [7:0]  shift_amount;
    } chan_t;

endpackage

@@ hw/rtl/imrq_if.sv @@
// Channel interfaces: activation and weight pairs in, requantized results out.
interface imrq_pair_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] activation;
    logic signed [7:0] weight;
    logic              last_of_tile;
    logic              last_of_output;
    logic signed [31:0] bias;
    logic signed [31:0] multiplier;
    logic [7:0]        shift_amount;

    modport source (
        output valid, activation, weight, last_of_tile, last_of_output,
               bias, multiplier, shift_amount,
        input  ready
    );
    modport sink (
        input  valid, activation, weight, last_of_tile, last_of_output,
               bias, multiplier, shift_amount,
        output ready
    );
endinterface

interface imrq_result_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  output_value;
    logic signed [26:0] raw_accumulator;
    logic [1:0]         status;

    modport source (
        output valid, output_value, raw_accumulator, status,
        input  ready
    );
    modport sink (
        input  valid, output_value, raw_accumulator, status,
        output ready
    );
endinterface

@@ hw/rtl/imrq_accum.sv @@
// Product, row, tile and output accumulation stages with range checks.
module imrq_accum
    import imrq_pkg::*;
#(
    parameter int ROW_SUM_BITS = ROW_SUM_BITS_DEF,
    parameter int ACC_BITS     = ACC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [3:0]                 taps_per_row,
    input  logic                       in_valid,
    input  logic signed [7:0]          activation,
    input  logic signed [7:0]          weight,
    input  logic                       last_of_tile,
    input  logic                       last_of_output,
    input  chan_t                      in_chan,
    output logic                       out_valid,
    output logic signed [ACC_BITS-1:0] out_total,
    output logic                       out_overflow,
    output chan_t                      out_chan
);

    localparam int TILE_BITS = ROW_SUM_BITS + TILE_GROWTH;
    localparam int RW        = ROW_SUM_BITS + 1;
    localparam int TW        = TILE_BITS + 1;
    localparam int SW        = ((ACC_BITS > TILE_BITS) ? ACC_BITS : TILE_BITS) + 1;

    // product stage
    logic                           p_vld_reg;
    logic signed [15:0]             p_prod_reg;
    logic                           p_lt_reg;
    logic                           p_lo_reg;
    chan_t                          p_chan_reg;

    // row stage
    logic [3:0]                     tap_count_reg;
    logic signed [ROW_SUM_BITS-1:0] row_partial_reg;
    logic                           r_vld_reg;
    logic                           r_close_reg;
    logic signed [ROW_SUM_BITS-1:0] r_row_reg;
    logic                           r_ovf_reg;
    logic                           r_lt_reg;
    logic                           r_lo_reg;
    chan_t                          r_chan_reg;

    // tile stage
    logic signed [TILE_BITS-1:0]    tile_total_reg;
    logic                           t_vld_reg;
    logic                           t_close_reg;
    logic signed [TILE_BITS-1:0]    t_tile_reg;
    logic                           t_ovf_reg;
    logic                           t_lo_reg;
    chan_t                          t_chan_reg;

    // output stage
    logic signed [ACC_BITS-1:0]     output_total_reg;
    logic                           overflow_seen_reg;
    logic                           o_vld_reg;
    logic signed [ACC_BITS-1:0]     o_total_reg;
    logic                           o_ovf_reg;
    chan_t                          o_chan_reg;

    logic signed [RW-1:0]           row_sum;
    logic signed [RW-1:0]           row_hi;
    logic                           row_ovf;
    logic signed [ROW_SUM_BITS-1:0] row_wrap;
    logic [3:0]                     tap_next;
    logic [3:0]                     taps_eff;
    logic                           row_close;

    logic signed [TW-1:0]           tile_sum;
    logic signed [TW-1:0]           tile_hi;
    logic                           tile_ovf;
    logic signed [TILE_BITS-1:0]    tile_wrap;
    logic                           tile_close;

    logic signed [SW-1:0]           out_sum;
    logic signed [SW-1:0]           out_hi;
    logic                           out_ovf;
    logic signed [ACC_BITS-1:0]     total_next;
    logic                           sticky_next;

    assign row_sum   = RW'(row_partial_reg) + RW'(p_prod_reg);
    assign row_hi    = row_sum >>> (ROW_SUM_BITS - 1);
    assign row_ovf   = !((row_hi == '0) || (row_hi == '1));
    assign row_wrap  = row_sum[ROW_SUM_BITS-1:0];
    assign tap_next  = tap_count_reg + 4'd1;
    assign taps_eff  = (taps_per_row == '0) ? 4'd1 : taps_per_row;
    assign row_close = (tap_next >= taps_eff) || p_lt_reg || p_lo_reg;

    assign tile_sum   = TW'(tile_total_reg) + TW'(r_row_reg);
    assign tile_hi    = tile_sum >>> (TILE_BITS - 1);
    assign tile_ovf   = r_close_reg && !((tile_hi == '0) || (tile_hi == '1));
    assign tile_wrap  = tile_sum[TILE_BITS-1:0];
    assign tile_close = r_lt_reg || r_lo_reg;

    assign out_sum     = SW'(output_total_reg) + SW'(t_tile_reg);
    assign out_hi      = out_sum >>> (ACC_BITS - 1);
    assign out_ovf     = t_close_reg && !((out_hi == '0) || (out_hi == '1));
    assign total_next  = t_close_reg ? out_sum[ACC_BITS-1:0] : output_total_reg;
    assign sticky_next = overflow_seen_reg || t_ovf_reg || out_ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg         <= 1'b0;
            r_vld_reg         <= 1'b0;
            t_vld_reg         <= 1'b0;
            o_vld_reg         <= 1'b0;
            tap_count_reg     <= '0;
            row_partial_reg   <= '0;
            tile_total_reg    <= '0;
            output_total_reg  <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_vld_reg <= in_valid;
            r_vld_reg <= p_vld_reg;
            t_vld_reg <= r_vld_reg;
            o_vld_reg <= t_vld_reg && t_lo_reg;
            if (p_vld_reg)
            begin
                if (row_close)
                begin
                    tap_count_reg   <= '0;
                    row_partial_reg <= '0;
                end
                else
                begin
                    tap_count_reg   <= tap_next;
                    row_partial_reg <= row_wrap;
                end
            end
            if (r_vld_reg)
            begin
                if (tile_close)
                begin
                    tile_total_reg <= '0;
                end
                else if (r_close_reg)
                begin
                    tile_total_reg <= tile_wrap;
                end
            end
            if (t_vld_reg)
            begin
                if (t_lo_reg)
                begin
                    output_total_reg  <= '0;
                    overflow_seen_reg <= 1'b0;
                end
                else
                begin
                    output_total_reg  <= total_next;
                    overflow_seen_reg <= sticky_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_prod_reg  <= activation * weight;
            p_lt_reg    <= last_of_tile;
            p_lo_reg    <= last_of_output;
            p_chan_reg  <= in_chan;

            r_close_reg <= row_close;
            r_row_reg   <= row_wrap;
            r_ovf_reg   <= row_ovf;
            r_lt_reg    <= p_lt_reg;
            r_lo_reg    <= p_lo_reg;
            r_chan_reg  <= p_chan_reg;

            t_close_reg <= tile_close;
            t_tile_reg  <= tile_wrap;
            t_ovf_reg   <= r_ovf_reg || tile_ovf;
            t_lo_reg    <= r_lo_reg;
            t_chan_reg  <= r_chan_reg;

            o_total_reg <= total_next;
            o_ovf_reg   <= sticky_next;
            o_chan_reg  <= t_chan_reg;
        end
    end

    assign out_valid    = o_vld_reg;
    assign out_total    = o_total_reg;
    assign out_overflow = o_ovf_reg;
    assign out_chan     = o_chan_reg;

endmodule

@@ hw/rtl/imrq_requant.sv @@
// Bias, parameter checks, requantizing multiply, rounding shift, clamp and result register.
module imrq_requant
    import imrq_pkg::*;
#(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       relu_enable,
    input  logic                       in_valid,
    input  logic signed [ACC_BITS-1:0] in_total,
    input  logic                       in_overflow,
    input  chan_t                      in_chan,
    output logic                       out_valid,
    output logic signed [7:0]          out_value,
    output logic signed [RAW_BITS-1:0] out_raw,
    output logic [1:0]                 out_status
);

    localparam int BW = ((ACC_BITS > 32) ? ACC_BITS : 32) + 1;
    localparam int PW = ACC_BITS + MULT_BITS + 1;

    logic                       a_vld_reg;
    logic signed [ACC_BITS-1:0] a_biased_reg;
    logic [MULT_BITS-1:0]       a_mult_reg;
    logic [SHIFT_BITS-1:0]      a_sh_reg;
    logic [1:0]                 a_status_reg;
    logic [RAW_BITS-1:0]        a_raw_reg;

    logic                       b_vld_reg;
    logic signed [PW-1:0]       b_prod_reg;
    logic [SHIFT_BITS-1:0]      b_sh_reg;
    logic [1:0]                 b_status_reg;
    logic [RAW_BITS-1:0]        b_raw_reg;

    logic                       out_vld_reg;
    logic signed [7:0]          out_value_reg;
    logic [RAW_BITS-1:0]        out_raw_reg;
    logic [1:0]                 out_status_reg;

    logic signed [BW-1:0]       biased;
    logic signed [BW-1:0]       biased_hi;
    logic                       params_ok;
    logic signed [63:0]         total_ext;
    logic [1:0]                 status_next;

    logic                       neg;
    logic [PW-1:0]              mag;
    logic [PW:0]                round_bit;
    logic [PW:0]                rounded;
    logic [PW:0]                quot;
    logic signed [7:0]          value_next;

    assign biased    = BW'(in_total) + BW'($signed(in_chan.bias));
    assign biased_hi = biased >>> (ACC_BITS - 1);
    assign params_ok = ((biased_hi == '0) || (biased_hi == '1))
                    && ($signed(in_chan.multiplier) >= MULT_MIN)
                    && ($signed(in_chan.multiplier) <= MULT_MAX)
                    && (in_chan.shift_amount >= SHIFT_MIN)
                    && (in_chan.shift_amount <= SHIFT_MAX);
    assign total_ext = 64'(in_total);

    always_comb
    begin
        priority if (in_overflow)
            status_next = STATUS_OVERFLOW;
        else if (!params_ok)
            status_next = STATUS_REQUANT;
        else
            status_next = STATUS_OK;
    end

    assign neg       = b_prod_reg[PW-1];
    assign mag       = neg ? -b_prod_reg : b_prod_reg;
    assign round_bit = {{PW{1'b0}}, 1'b1} << (b_sh_reg - 1'b1);
    assign rounded   = {1'b0, mag} + round_bit;
    assign quot      = rounded >> b_sh_reg;

    always_comb
    begin
        priority if (b_status_reg != STATUS_OK)
            value_next = '0;
        else if (neg && relu_enable)
            value_next = '0;
        else if (neg && (quot > (PW + 1)'(128)))
            value_next = -8'sd128;
        else if (neg)
            value_next = -quot[7:0];
        else if (quot > (PW + 1)'(127))
            value_next = 8'sd127;
        else
            value_next = quot[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_vld_reg   <= in_valid;
            b_vld_reg   <= a_vld_reg;
            out_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_biased_reg   <= biased[ACC_BITS-1:0];
            a_mult_reg     <= in_chan.multiplier[MULT_BITS-1:0];
            a_sh_reg       <= in_chan.shift_amount[SHIFT_BITS-1:0];
            a_status_reg   <= status_next;
            a_raw_reg      <= in_overflow ? '0 : total_ext[RAW_BITS-1:0];

            b_prod_reg     <= PW'(a_biased_reg) * PW'($signed({1'b0, a_mult_reg}));
            b_sh_reg       <= a_sh_reg;
            b_status_reg   <= a_status_reg;
            b_raw_reg      <= a_raw_reg;

            out_value_reg  <= value_next;
            out_raw_reg    <= b_raw_reg;
            out_status_reg <= b_status_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_value  = out_value_reg;
    assign out_raw    = out_raw_reg;
    assign out_status = out_status_reg;

endmodule

@@ hw/rtl/int8_mac_reduce_requantize.sv @@
// Top level: int8 dot product with row, tile and output range checks and requantization.
//
//  channel   dir  handshake      payload
//  pairs     in   valid/ready    activation, weight, last_of_tile, last_of_output,
//                                bias, multiplier, shift_amount
//  results   out  valid/ready    output_value, raw_accumulator, status
//  cfg       in   cfg_we         cfg_index, cfg_data
//
// One pair per cycle unless a waiting result holds the pipeline; a result leaves once the last
// pair of its output has passed the seven-stage pipeline: product, row, tile and output sums,
// bias and checks, requantizing multiply, rounding and clamp into the result register.
// Reset clears running sums, valid and sticky overflow flags; relu_enable to 0, taps_per_row to 1.
// A waiting result with results.ready low holds the whole pipeline; pairs.ready follows it.
module int8_mac_reduce_requantize
    import imrq_pkg::*;
#(
    parameter int ROW_SUM_BITS = ROW_SUM_BITS_DEF,
    parameter int ACC_BITS     = ACC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data,
    imrq_pair_if.sink           pairs,
    imrq_result_if.source       results
);

    logic                       relu_enable_reg;
    logic [3:0]                 taps_per_row_reg;
    logic                       advance;
    chan_t                      in_chan;
    logic                       acc_valid;
    logic signed [ACC_BITS-1:0] acc_total;
    logic                       acc_overflow;
    chan_t                      acc_chan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relu_enable_reg  <= 1'b0;
            taps_per_row_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RELU_ENABLE:  relu_enable_reg  <= cfg_data[0];
                CFG_TAPS_PER_ROW: taps_per_row_reg <= cfg_data;
                default:          relu_enable_reg  <= relu_enable_reg;
            endcase
        end
    end

    // hold everything while a finished result waits
    assign advance      = !results.valid || results.ready;
    assign pairs.ready  = advance;

    assign in_chan.bias         = pairs.bias;
    assign in_chan.multiplier   = pairs.multiplier;
    assign in_chan.shift_amount = pairs.shift_amount;

    imrq_accum #(
        .ROW_SUM_BITS (ROW_SUM_BITS),
        .ACC_BITS     (ACC_BITS)
    ) u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .taps_per_row   (taps_per_row_reg),
        .in_valid       (pairs.valid),
        .activation     (pairs.activation),
        .weight         (pairs.weight),
        .last_of_tile   (pairs.last_of_tile),
        .last_of_output (pairs.last_of_output),
        .in_chan        (in_chan),
        .out_valid      (acc_valid),
        .out_total      (acc_total),
        .out_overflow   (acc_overflow),
        .out_chan       (acc_chan)
    );

    imrq_requant #(
        .ACC_BITS (ACC_BITS)
    ) u_requant (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .relu_enable (relu_enable_reg),
        .in_valid    (acc_valid),
        .in_total    (acc_total),
        .in_overflow (acc_overflow),
        .in_chan     (acc_chan),
        .out_valid   (results.valid),
        .out_value   (results.output_value),
        .out_raw     (results.raw_accumulator),
        .out_status  (results.status)
    );

endmodule
